// File: rtl/brat_pkg.sv
// Shared types, constants and command codes of the rational approximation block.
package brat_pkg;

	localparam int NUM_W = 16;
	localparam int DEN_W = 30;
	localparam int OUT_W = 32;
	localparam int CFG_W = 16;
	localparam int DIG_W = 4;

	localparam logic [DEN_W-1:0] DEN_LIMIT = 30'd1000000000;
	localparam logic [30:0]      INT_LIMIT = 31'h7FFFFFFF;

	localparam logic [NUM_W-1:0] BOUND_RESET  = 16'd500;
	localparam logic [DIG_W-1:0] DIGITS_RESET = 4'd5;

	localparam logic CFG_SEARCH_BOUND   = 1'b0;
	localparam logic CFG_DECIMAL_DIGITS = 1'b1;

	localparam logic DIV_BY_FRAC = 1'b0;
	localparam logic DIV_BY_DEN  = 1'b1;

	localparam logic [1:0] MUL_WHOLE_DEN = 2'd0;
	localparam logic [1:0] MUL_FRAC_POW  = 2'd1;
	localparam logic [1:0] MUL_WHOLE_POW = 2'd2;

	localparam logic [1:0] FIN_ZERO     = 2'd0;
	localparam logic [1:0] FIN_SEARCH   = 2'd1;
	localparam logic [1:0] FIN_FALLBACK = 2'd2;

	typedef struct packed {
		logic       load;
		logic       div_start;
		logic       div_sel;
		logic       cap_a;
		logic       cap_err;
		logic       upd_best;
		logic       next_n;
		logic       mul_start;
		logic [1:0] mul_sel;
		logic       cap_rs;
		logic       cap_nt;
		logic       halve;
		logic       finish;
		logic [1:0] fin_sel;
	} brat_cmd_t;

	typedef struct packed {
		logic f_zero;
		logic n_in_range;
		logic div_done;
		logic better;
		logic err_zero;
		logic mul_done;
		logic over_int;
		logic even_both;
	} brat_sts_t;

	// 10^d, digit counts above nine give 10^9
	function automatic logic [DEN_W-1:0] pow10(input logic [DIG_W-1:0] d);
		logic [DEN_W-1:0] r;
		case (d)
			4'd0: r = 30'd1;
			4'd1: r = 30'd10;
			4'd2: r = 30'd100;
			4'd3: r = 30'd1000;
			4'd4: r = 30'd10000;
			4'd5: r = 30'd100000;
			4'd6: r = 30'd1000000;
			4'd7: r = 30'd10000000;
			4'd8: r = 30'd100000000;
			default: r = 30'd1000000000;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/best_rational_approximation_top.sv
// Top level of the best rational approximation block: controller plus datapath.
// Sequence: a zero fraction skips the search; otherwise each trial numerator runs the shared
// bit-serial divider twice, then the whole-part multiply follows, and the fallback path adds
// two more multiplies and a halving loop.
// Throughput: one item at a time; the next start is taken in the cycle done is high.
// Reset clears the controller and loads the config defaults; the receiver cannot stall.
module best_rational_approximation_top import brat_pkg::*; #(
	parameter int FRAC_BITS  = 32,
	parameter int WHOLE_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  done,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic [WHOLE_BITS-1:0] whole_part,
	input  logic [FRAC_BITS-1:0]  fraction_part,
	output logic [OUT_W-1:0]      numerator_out,
	output logic [DEN_W-1:0]      denominator_out,
	output logic                  used_fallback,
	output logic                  saturated
);
	brat_cmd_t cmd;
	brat_sts_t sts;

	// sequence each transfer: search, fold in the whole part, fall back when too large
	brat_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts),
		.cmd(cmd), .busy(busy), .done(done)
	);

	// hold operands, run the divider and multiplier, and register the result
	brat_dp #(.FRAC_BITS(FRAC_BITS), .WHOLE_BITS(WHOLE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.whole_part(whole_part), .fraction_part(fraction_part),
		.cmd(cmd), .sts(sts),
		.numerator_out(numerator_out), .denominator_out(denominator_out),
		.used_fallback(used_fallback), .saturated(saturated)
	);
endmodule

// File: rtl/brat_div.sv
// Restoring divider: round_half_up(n * 2^FRAC_BITS / d), one quotient bit per cycle.
module brat_div import brat_pkg::*; #(
	parameter int FRAC_BITS = 32,
	parameter int DW        = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [NUM_W-1:0]            n,
	input  logic [DW-1:0]               d,
	output logic                        done,
	output logic [NUM_W+FRAC_BITS:0]    quo
);
	localparam int DVW = NUM_W + FRAC_BITS;
	localparam int CW  = $clog2(DVW);

	logic            run_q, fin_q, done_q;
	logic [CW-1:0]   cnt_q;
	logic [DW-1:0]   rem_q, dsr_q;
	logic [DVW-1:0]  dvd_q, quo_q;
	logic [DVW:0]    res_q;
	logic [DW:0]     trial;
	logic            ge;
	logic [DW-1:0]   rem_n;
	logic            rnd;

	assign trial = {rem_q, dvd_q[DVW-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign rem_n = ge ? DW'(trial - {1'b0, dsr_q}) : trial[DW-1:0];
	assign rnd   = {rem_q, 1'b0} >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DVW - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {n, {FRAC_BITS{1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
			dsr_q <= d;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DVW-2:0], 1'b0};
			rem_q <= rem_n;
			quo_q <= {quo_q[DVW-2:0], ge};
		end
		if (fin_q)
			res_q <= {1'b0, quo_q} + (DVW+1)'(rnd);
	end

	assign done = done_q;
	assign quo  = res_q;
endmodule

// File: rtl/brat_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
module brat_mul #(
	parameter int AW = 32,
	parameter int BW = 30
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic             done,
	output logic [AW+BW-1:0] prod
);
	localparam int PW = AW + BW;
	localparam int CW = $clog2(BW);

	logic           run_q, done_q;
	logic [CW-1:0]  cnt_q;
	logic [PW-1:0]  acc_q, mc_q;
	logic [BW-1:0]  mb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(BW - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q  <= PW'(a);
			mb_q  <= b;
		end else if (run_q) begin
			if (mb_q[0])
				acc_q <= acc_q + mc_q;
			mc_q <= {mc_q[PW-2:0], 1'b0};
			mb_q <= mb_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

// File: rtl/brat_dp.sv
// Datapath: config registers, search registers, shared divider and multiplier, result registers.
module brat_dp import brat_pkg::*; #(
	parameter int FRAC_BITS  = 32,
	parameter int WHOLE_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic [WHOLE_BITS-1:0] whole_part,
	input  logic [FRAC_BITS-1:0]  fraction_part,
	input  brat_cmd_t             cmd,
	output brat_sts_t             sts,
	output logic [OUT_W-1:0]      numerator_out,
	output logic [DEN_W-1:0]      denominator_out,
	output logic                  used_fallback,
	output logic                  saturated
);
	localparam int DW  = (FRAC_BITS > DEN_W) ? FRAC_BITS : DEN_W;
	localparam int MCW = (FRAC_BITS > WHOLE_BITS) ? FRAC_BITS : WHOLE_BITS;
	localparam int PW  = MCW + DEN_W;
	localparam int QW  = NUM_W + FRAC_BITS + 1;
	localparam int EW  = FRAC_BITS + 2;
	localparam int NTW = WHOLE_BITS + DEN_W + 1;

	logic [NUM_W-1:0]      bound_q, n_q, best_n_q;
	logic [DIG_W-1:0]      digits_q;
	logic [WHOLE_BITS-1:0] whole_q;
	logic [FRAC_BITS-1:0]  frac_q;
	logic [DEN_W-1:0]      best_d_q, a_q, rs_q, dt_q;
	logic [EW-1:0]         err_q, least_q;
	logic [NTW-1:0]        nt_q;

	logic [DEN_W-1:0] pow_r;
	logic [DW-1:0]    div_d;
	logic             div_done;
	logic [QW-1:0]    div_q, q_lim, q_clip;
	logic [EW-1:0]    q_e, f_e, err_n;
	logic [DEN_W-1:0] a_n;
	logic [MCW-1:0]   mul_a;
	logic [DEN_W-1:0] mul_b;
	logic             mul_done;
	logic [PW-1:0]    mul_p;
	logic [PW:0]      rs_sum;
	logic             exact, sat_n;

	assign pow_r = pow10(digits_q);

	// hold the config registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q  <= BOUND_RESET;
			digits_q <= DIGITS_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SEARCH_BOUND:   bound_q  <= cfg_wdata;
				CFG_DECIMAL_DIGITS: digits_q <= cfg_wdata[DIG_W-1:0];
				default: ;
			endcase
		end
	end

	assign div_d = (cmd.div_sel == DIV_BY_DEN) ? DW'(a_q) : DW'(frac_q);

	brat_div #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.n(n_q), .d(div_d), .done(div_done), .quo(div_q)
	);

	always_comb begin
		case (cmd.mul_sel)
			MUL_FRAC_POW: begin
				mul_a = MCW'(frac_q);
				mul_b = pow_r;
			end
			MUL_WHOLE_POW: begin
				mul_a = MCW'(whole_q);
				mul_b = pow_r;
			end
			default: begin
				// an exact trial starts the multiply in the cycle it becomes the best
				mul_a = MCW'(whole_q);
				mul_b = cmd.upd_best ? a_q : best_d_q;
			end
		endcase
	end

	brat_mul #(.AW(MCW), .BW(DEN_W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(cmd.mul_start),
		.a(mul_a), .b(mul_b), .done(mul_done), .prod(mul_p)
	);

	assign a_n    = (div_q > QW'(DEN_LIMIT)) ? DEN_LIMIT : div_q[DEN_W-1:0];
	assign q_lim  = QW'(1) << (FRAC_BITS + 1);
	assign q_clip = (div_q > q_lim) ? q_lim : div_q;
	assign q_e    = q_clip[EW-1:0];
	assign f_e    = EW'(frac_q);
	assign err_n  = (q_e >= f_e) ? (q_e - f_e) : (f_e - q_e);

	assign rs_sum = (PW+1)'(mul_p) + ((PW+1)'(1) << (FRAC_BITS - 1));
	assign exact  = (rs_q == '0) || (rs_q == pow_r);
	assign sat_n  = |nt_q[NTW-1:OUT_W];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			whole_q  <= whole_part;
			frac_q   <= fraction_part;
			n_q      <= NUM_W'(1);
			best_n_q <= '0;
			best_d_q <= DEN_W'(1);
			least_q  <= EW'(fraction_part);
		end
		if (cmd.cap_a)
			a_q <= a_n;
		if (cmd.cap_err)
			err_q <= err_n;
		if (cmd.upd_best) begin
			best_n_q <= n_q;
			best_d_q <= a_q;
			least_q  <= err_q;
		end
		if (cmd.next_n)
			n_q <= n_q + 1'b1;
		if (cmd.cap_rs)
			rs_q <= rs_sum[FRAC_BITS +: DEN_W];
		if (cmd.cap_nt) begin
			// a power of ten divides the sum only when the rounded digits are 0 or 10^D
			if (exact) begin
				nt_q <= NTW'(whole_q) + NTW'(rs_q == pow_r);
				dt_q <= DEN_W'(1);
			end else begin
				nt_q <= NTW'(mul_p[NTW-2:0]) + NTW'(rs_q);
				dt_q <= pow_r;
			end
		end else if (cmd.halve) begin
			nt_q <= nt_q >> 1;
			dt_q <= dt_q >> 1;
		end
		if (cmd.finish) begin
			case (cmd.fin_sel)
				FIN_SEARCH: begin
					numerator_out   <= OUT_W'(best_n_q) + mul_p[OUT_W-1:0];
					denominator_out <= best_d_q;
					used_fallback   <= 1'b0;
					saturated       <= 1'b0;
				end
				FIN_FALLBACK: begin
					numerator_out   <= sat_n ? {OUT_W{1'b1}} : nt_q[OUT_W-1:0];
					denominator_out <= dt_q;
					used_fallback   <= 1'b1;
					saturated       <= sat_n;
				end
				default: begin
					numerator_out   <= OUT_W'(whole_q);
					denominator_out <= DEN_W'(1);
					used_fallback   <= 1'b0;
					saturated       <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		sts.f_zero     = (frac_q == '0);
		sts.n_in_range = (n_q < bound_q);
		sts.div_done   = div_done;
		sts.better     = (err_q < least_q);
		sts.err_zero   = (err_q == '0);
		sts.mul_done   = mul_done;
		sts.over_int   = (mul_p > PW'(INT_LIMIT));
		sts.even_both  = !nt_q[0] && !dt_q[0];
	end
endmodule

// File: rtl/brat_ctrl.sv
// Controller: sequences the trial search, the fallback conversion and the result transfer.
module brat_ctrl import brat_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  brat_sts_t sts,
	output brat_cmd_t cmd,
	output logic      busy,
	output logic      done
);
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_CHECK   = 4'd1;
	localparam logic [3:0] S_TEST    = 4'd2;
	localparam logic [3:0] S_DIV_A   = 4'd3;
	localparam logic [3:0] S_START_Q = 4'd4;
	localparam logic [3:0] S_DIV_Q   = 4'd5;
	localparam logic [3:0] S_UPDATE  = 4'd6;
	localparam logic [3:0] S_MUL_WD  = 4'd7;
	localparam logic [3:0] S_DECIDE  = 4'd8;
	localparam logic [3:0] S_MUL_FR  = 4'd9;
	localparam logic [3:0] S_MUL_WR  = 4'd10;
	localparam logic [3:0] S_REDUCE  = 4'd11;

	logic [3:0] state_q, state_d;
	logic       done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.f_zero) begin
					cmd.finish  = 1'b1;
					cmd.fin_sel = FIN_ZERO;
					state_d     = S_IDLE;
				end else begin
					state_d = S_TEST;
				end
			end
			S_TEST: begin
				if (sts.n_in_range) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_BY_FRAC;
					state_d       = S_DIV_A;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MUL_WHOLE_DEN;
					state_d       = S_MUL_WD;
				end
			end
			S_DIV_A: begin
				if (sts.div_done) begin
					cmd.cap_a = 1'b1;
					state_d   = S_START_Q;
				end
			end
			S_START_Q: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_BY_DEN;
				state_d       = S_DIV_Q;
			end
			S_DIV_Q: begin
				if (sts.div_done) begin
					cmd.cap_err = 1'b1;
					state_d     = S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.upd_best = sts.better;
				if (sts.better && sts.err_zero) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MUL_WHOLE_DEN;
					state_d       = S_MUL_WD;
				end else begin
					cmd.next_n = 1'b1;
					state_d    = S_TEST;
				end
			end
			S_MUL_WD: begin
				if (sts.mul_done)
					state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.over_int) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MUL_FRAC_POW;
					state_d       = S_MUL_FR;
				end else begin
					cmd.finish  = 1'b1;
					cmd.fin_sel = FIN_SEARCH;
					state_d     = S_IDLE;
				end
			end
			S_MUL_FR: begin
				if (sts.mul_done) begin
					cmd.cap_rs    = 1'b1;
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MUL_WHOLE_POW;
					state_d       = S_MUL_WR;
				end
			end
			S_MUL_WR: begin
				if (sts.mul_done) begin
					cmd.cap_nt = 1'b1;
					state_d    = S_REDUCE;
				end
			end
			S_REDUCE: begin
				if (sts.even_both) begin
					cmd.halve = 1'b1;
				end else begin
					cmd.finish  = 1'b1;
					cmd.fin_sel = FIN_FALLBACK;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
endmodule
